FILE: rtl/core/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  // Number of quotient bits and square root digits resolved, one per stage.
  localparam int unsigned NIT       = 32;
  localparam int unsigned QDEPTH    = 2;
  // Width of the scaled division numerator.
  localparam int unsigned MW        = 64 + FRAC_BITS + 1;
  localparam int unsigned HW        = MW - NIT;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MAG  = 3'd4,
    OP_NONE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    op_e                op;
    logic [DATA_W-1:0]  ar;
    logic [DATA_W-1:0]  ai;
    logic [DATA_W-1:0]  br;
    logic [DATA_W-1:0]  bi;
  } item_t;

  // Handshake between the front end and the queue.
  typedef struct packed {
    logic push;
  } qctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit.
// One command is taken per clock cycle and each gives one result, shown for a
// single cycle with done_o high, after it passes the command register, the queue,
// the stage registers for products, sums, rounding and the scaled numerators, 32
// stages that each resolve one quotient bit of the divider and one digit of the
// square root, and the output register. All operations take this same path, so
// results leave in command order. The receiver cannot stall, and busy stays low
// in normal use.
`default_nettype none
module complex_arithmetic_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [31:0] a_real_i,
  input  wire logic [31:0] a_imag_i,
  input  wire logic [31:0] b_real_i,
  input  wire logic [31:0] b_imag_i,
  output logic             done_o,
  output logic [31:0]      res_real_o,
  output logic [31:0]      res_imag_o,
  output logic [1:0]       status_o
);
  import cau_pkg::*;

  item_t fr_item, q_item;
  qctl_t qctl;
  logic  qfull, q_valid;

  cau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .req_type_i (req_type_i),
    .a_real_i   (a_real_i),
    .a_imag_i   (a_imag_i),
    .b_real_i   (b_real_i),
    .b_imag_i   (b_imag_i),
    .item_o     (fr_item),
    .qctl_o     (qctl),
    .qfull_i    (qfull)
  );

  cau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qctl_i  (qctl),
    .item_i  (fr_item),
    .full_o  (qfull),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  cau_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .item_i     (q_item),
    .done_o     (done_o),
    .res_real_o (res_real_o),
    .res_imag_o (res_imag_o),
    .status_o   (status_o)
  );
endmodule
`default_nettype wire

FILE: rtl/core/cau_front.sv
// Front end: takes in commands and decodes the operation code.
`default_nettype none
module cau_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire logic [2:0]    req_type_i,
  input  wire logic [31:0]   a_real_i,
  input  wire logic [31:0]   a_imag_i,
  input  wire logic [31:0]   b_real_i,
  input  wire logic [31:0]   b_imag_i,
  output cau_pkg::item_t     item_o,
  output cau_pkg::qctl_t     qctl_o,
  input  wire logic          qfull_i
);
  import cau_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  op_e   op_dec;
  logic  take;
  logic  push;

  // Map the raw code onto an operation; unused codes become no-ops.
  always_comb begin
    case (req_type_i)
      3'd0:    op_dec = OP_ADD;
      3'd1:    op_dec = OP_SUB;
      3'd2:    op_dec = OP_MUL;
      3'd3:    op_dec = OP_DIV;
      3'd4:    op_dec = OP_MAG;
      default: op_dec = OP_NONE;
    endcase
  end

  assign push    = valid_q && !qfull_i;
  assign busy_o  = valid_q && qfull_i;
  assign take    = start_i && !busy_o;
  assign valid_d = take || (valid_q && !push);

  // Control state for the holding register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on every transfer.
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{op: op_dec, ar: a_real_i, ai: a_imag_i, br: b_real_i, bi: b_imag_i};
    end
  end

  assign item_o      = item_q;
  assign qctl_o.push = push;
endmodule
`default_nettype wire

FILE: rtl/core/cau_queue.sv
// Short queue between the front end and the execution pipeline.
`default_nettype none
module cau_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cau_pkg::qctl_t qctl_i,
  input  wire cau_pkg::item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  output cau_pkg::item_t     item_o
);
  import cau_pkg::*;

  item_t       mem_q [QDEPTH];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;

  // The back end never stalls, so any stored item leaves at once.
  assign pop     = (cnt_q != 2'd0);
  assign valid_o = pop;
  assign item_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == 2'(QDEPTH));

  always_comb begin
    cnt_d = cnt_q;
    if (qctl_i.push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!qctl_i.push && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (qctl_i.push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (qctl_i.push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/cau_back.sv
// Execution pipeline: products, sums, rounding, divider and square root stages.
`default_nettype none
module cau_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire cau_pkg::item_t item_i,
  output logic               done_o,
  output logic [31:0]        res_real_o,
  output logic [31:0]        res_imag_o,
  output logic [1:0]         status_o
);
  import cau_pkg::*;

  localparam logic [64:0] HALF = 65'((65'(1) << FRAC_BITS) >> 1);

  // Iteration stage contents.
  typedef struct packed {
    op_e                op;
    logic [31:0]        pre_re;
    logic [31:0]        pre_im;
    status_e            pre_st;
    logic [63:0]        d;
    logic [1:0]         neg;
    logic [1:0]         big;
    logic [1:0][63:0]   rem;
    logic [1:0][31:0]   mlo;
    logic [1:0][31:0]   q;
    logic [63:0]        sx;
    logic [33:0]        srem;
    logic [31:0]        sroot;
  } it_t;

  // Stage 1: products and add/subtract.
  logic               v1_q;
  op_e                op1_q;
  logic signed [63:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [63:0] sq_ar_q, sq_ai_q, sq_br_q, sq_bi_q;
  logic [32:0]        as_re_q, as_im_q;
  logic signed [31:0] ar, ai, br, bi;
  logic [32:0]        as_re, as_im;

  assign ar = item_i.ar;
  assign ai = item_i.ai;
  assign br = item_i.br;
  assign bi = item_i.bi;
  assign as_re = (item_i.op == OP_SUB) ? {ar[31], ar} - {br[31], br}
                                       : {ar[31], ar} + {br[31], br};
  assign as_im = (item_i.op == OP_SUB) ? {ai[31], ai} - {bi[31], bi}
                                       : {ai[31], ai} + {bi[31], bi};

  always_ff @(posedge clk_i) begin
    op1_q   <= item_i.op;
    p_rr_q  <= ar * br;
    p_ii_q  <= ai * bi;
    p_ri_q  <= ar * bi;
    p_ir_q  <= ai * br;
    sq_ar_q <= ar * ar;
    sq_ai_q <= ai * ai;
    sq_br_q <= br * br;
    sq_bi_q <= bi * bi;
    as_re_q <= as_re;
    as_im_q <= as_im;
  end

  // Stage 2: sums of products, divisor and squared magnitude.
  logic        v2_q;
  op_e         op2_q;
  logic [64:0] v_re_q, v_im_q;
  logic [63:0] d2_q, s2_q;
  logic [32:0] as_re2_q, as_im2_q;
  logic [64:0] e_rr, e_ii, e_ri, e_ir;

  assign e_rr = {p_rr_q[63], p_rr_q};
  assign e_ii = {p_ii_q[63], p_ii_q};
  assign e_ri = {p_ri_q[63], p_ri_q};
  assign e_ir = {p_ir_q[63], p_ir_q};

  always_ff @(posedge clk_i) begin
    op2_q    <= op1_q;
    v_re_q   <= (op1_q == OP_MUL) ? e_rr - e_ii : e_rr + e_ii;
    v_im_q   <= (op1_q == OP_MUL) ? e_ri + e_ir : e_ir - e_ri;
    d2_q     <= sq_br_q + sq_bi_q;
    s2_q     <= sq_ar_q + sq_ai_q;
    as_re2_q <= as_re_q;
    as_im2_q <= as_im_q;
  end

  // Stage 3: rounding and saturation of simple results, numerator magnitudes.
  logic        v3_q;
  op_e         op3_q;
  logic [31:0] pre_re3_q, pre_im3_q;
  status_e     pre_st3_q;
  logic [63:0] mag_re_q, mag_im_q, d3_q, s3_q;
  logic [1:0]  neg3_q;
  logic [64:0] rnd_re, rnd_im, sh_re, sh_im;
  logic [31:0] pre_re, pre_im;
  logic        sat_re, sat_im;
  status_e     pre_st;

  assign rnd_re = v_re_q + HALF;
  assign rnd_im = v_im_q + HALF;
  assign sh_re  = 65'($signed(rnd_re) >>> FRAC_BITS);
  assign sh_im  = 65'($signed(rnd_im) >>> FRAC_BITS);

  always_comb begin
    pre_re = 32'd0;
    pre_im = 32'd0;
    sat_re = 1'b0;
    sat_im = 1'b0;
    pre_st = ST_OK;
    case (op2_q)
      OP_ADD, OP_SUB: begin
        sat_re = (as_re2_q[32] != as_re2_q[31]);
        sat_im = (as_im2_q[32] != as_im2_q[31]);
        pre_re = sat_re ? {as_re2_q[32], {31{~as_re2_q[32]}}} : as_re2_q[31:0];
        pre_im = sat_im ? {as_im2_q[32], {31{~as_im2_q[32]}}} : as_im2_q[31:0];
      end
      OP_MUL: begin
        sat_re = (sh_re[64:31] != {34{sh_re[64]}});
        sat_im = (sh_im[64:31] != {34{sh_im[64]}});
        pre_re = sat_re ? {sh_re[64], {31{~sh_re[64]}}} : sh_re[31:0];
        pre_im = sat_im ? {sh_im[64], {31{~sh_im[64]}}} : sh_im[31:0];
      end
      OP_DIV: begin
        if (d2_q == 64'd0) begin
          pre_st = ST_DIVZ;
        end
      end
      default: begin
        pre_re = 32'd0;
      end
    endcase
    if (sat_re || sat_im) begin
      pre_st = ST_SAT;
    end
  end

  always_ff @(posedge clk_i) begin
    op3_q     <= op2_q;
    pre_re3_q <= pre_re;
    pre_im3_q <= pre_im;
    pre_st3_q <= pre_st;
    mag_re_q  <= v_re_q[64] ? 64'(-v_re_q) : v_re_q[63:0];
    mag_im_q  <= v_im_q[64] ? 64'(-v_im_q) : v_im_q[63:0];
    neg3_q    <= {v_im_q[64], v_re_q[64]};
    d3_q      <= d2_q;
    s3_q      <= s2_q;
  end

  // Stage 4: scaled numerators with half the divisor added, overflow check.
  it_t          stg_q [NIT+1];
  it_t          stg_d [NIT];
  logic [NIT:0] stv_q;
  logic [MW-1:0] m_re, m_im;
  logic [HW-1:0] h_re, h_im;

  assign m_re = (MW'(mag_re_q) << FRAC_BITS) + MW'(d3_q >> 1);
  assign m_im = (MW'(mag_im_q) << FRAC_BITS) + MW'(d3_q >> 1);
  assign h_re = m_re[MW-1:NIT];
  assign h_im = m_im[MW-1:NIT];

  always_ff @(posedge clk_i) begin
    stg_q[0].op     <= op3_q;
    stg_q[0].pre_re <= pre_re3_q;
    stg_q[0].pre_im <= pre_im3_q;
    stg_q[0].pre_st <= pre_st3_q;
    stg_q[0].d      <= d3_q;
    stg_q[0].neg    <= neg3_q;
    stg_q[0].big    <= {(65'(h_im) >= 65'(d3_q)), (65'(h_re) >= 65'(d3_q))};
    stg_q[0].rem    <= {64'(h_im), 64'(h_re)};
    stg_q[0].mlo    <= {m_im[NIT-1:0], m_re[NIT-1:0]};
    stg_q[0].q      <= '0;
    stg_q[0].sx     <= s3_q;
    stg_q[0].srem   <= '0;
    stg_q[0].sroot  <= '0;
  end

  // Valid bits of stages one to four; the iteration stages carry their own.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      stv_q[0] <= 1'b0;
    end else begin
      v1_q     <= valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      stv_q[0] <= v3_q;
    end
  end

  // One quotient bit per lane and one root digit per stage.
  for (genvar k = 0; k < NIT; k++) begin : g_it
    logic [1:0][64:0] r2;
    logic [1:0]       ge;
    logic [35:0]      r4, trial;
    logic             sge;

    always_comb begin
      stg_d[k] = stg_q[k];
      for (int j = 0; j < 2; j++) begin
        r2[j] = {stg_q[k].rem[j], stg_q[k].mlo[j][31]};
        ge[j] = (r2[j] >= {1'b0, stg_q[k].d});
        stg_d[k].rem[j] = ge[j] ? 64'(r2[j] - {1'b0, stg_q[k].d}) : r2[j][63:0];
        stg_d[k].mlo[j] = {stg_q[k].mlo[j][30:0], 1'b0};
        stg_d[k].q[j]   = {stg_q[k].q[j][30:0], ge[j]};
      end
      r4    = {stg_q[k].srem, stg_q[k].sx[63:62]};
      trial = {2'b00, stg_q[k].sroot, 2'b01};
      sge   = (r4 >= trial);
      stg_d[k].srem  = sge ? 34'(r4 - trial) : r4[33:0];
      stg_d[k].sroot = {stg_q[k].sroot[30:0], sge};
      stg_d[k].sx    = {stg_q[k].sx[61:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stv_q[k+1] <= 1'b0;
      end else begin
        stv_q[k+1] <= stv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[k+1].op     <= stg_d[k].op;
      stg_q[k+1].pre_re <= stg_d[k].pre_re;
      stg_q[k+1].pre_im <= stg_d[k].pre_im;
      stg_q[k+1].pre_st <= stg_d[k].pre_st;
      stg_q[k+1].d      <= stg_d[k].d;
      stg_q[k+1].neg    <= stg_d[k].neg;
      stg_q[k+1].big    <= stg_d[k].big;
      stg_q[k+1].rem    <= stg_d[k].rem;
      stg_q[k+1].mlo    <= stg_d[k].mlo;
      stg_q[k+1].q      <= stg_d[k].q;
      stg_q[k+1].sx     <= stg_d[k].sx;
      stg_q[k+1].srem   <= stg_d[k].srem;
      stg_q[k+1].sroot  <= stg_d[k].sroot;
    end
  end

  // Final sign, saturation and result selection.
  it_t         fin;
  logic [1:0][31:0] dq;
  logic [1:0]  dsat;
  logic [32:0] root_r;
  logic        root_sat;
  logic [31:0] res_re_d, res_im_d;
  status_e     st_d;

  assign fin = stg_q[NIT];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      if (fin.neg[j]) begin
        dsat[j] = fin.big[j] || (fin.q[j] > 32'h8000_0000);
        dq[j]   = dsat[j] ? 32'h8000_0000 : 32'(-fin.q[j]);
      end else begin
        dsat[j] = fin.big[j] || fin.q[j][31];
        dq[j]   = dsat[j] ? 32'h7FFF_FFFF : fin.q[j];
      end
    end
    root_r   = {1'b0, fin.sroot} + 33'((34'(fin.sroot) < fin.srem) ? 1 : 0);
    root_sat = (root_r > 33'h0_7FFF_FFFF);
    res_re_d = fin.pre_re;
    res_im_d = fin.pre_im;
    st_d     = fin.pre_st;
    if (fin.op == OP_DIV && fin.pre_st != ST_DIVZ) begin
      res_re_d = dq[0];
      res_im_d = dq[1];
      st_d     = (dsat != 2'b00) ? ST_SAT : ST_OK;
    end else if (fin.op == OP_MAG) begin
      res_re_d = root_sat ? 32'h7FFF_FFFF : root_r[31:0];
      res_im_d = 32'd0;
      st_d     = root_sat ? ST_SAT : ST_OK;
    end
  end

  // Output register with its strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= stv_q[NIT];
    end
  end

  always_ff @(posedge clk_i) begin
    res_real_o <= res_re_d;
    res_imag_o <= res_im_d;
    status_o   <= st_d;
  end
endmodule
`default_nettype wire
